### src/bdl_pkg.sv
// Shared types and constants for the button debouncer.
// Register indexes, reset values and the structs passed between modules.
// No dependencies.
package bdl_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 2;

  // Register indexes on the configuration port
  localparam logic [IdxW-1:0] CFG_DEBOUNCE     = 2'd0;
  localparam logic [IdxW-1:0] CFG_LONG_PRESS   = 2'd1;
  localparam logic [IdxW-1:0] CFG_DOUBLE_CLICK = 2'd2;
  localparam logic [IdxW-1:0] CFG_ACTIVE_LEVEL = 2'd3;

  // Register reset values
  localparam logic [CfgW-1:0] DEBOUNCE_RST     = 16'd5;
  localparam logic [CfgW-1:0] LONG_PRESS_RST   = 16'd500;
  localparam logic [CfgW-1:0] DOUBLE_CLICK_RST = 16'd200;
  localparam logic            ACTIVE_LEVEL_RST = 1'b0;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] double_click_ms;
    logic            active_level;
  } cfg_t;

  typedef struct packed {
    logic             last_raw;
    logic             stable_level;
    logic [TimeW-1:0] stable_since;
    logic [TimeW-1:0] last_release_time;
    logic             long_flag;
    logic             double_flag;
    logic             press_reported;
    logic             release_reported;
  } state_t;

  localparam state_t STATE_RST = '{
    last_raw:          1'b1,
    stable_level:      1'b1,
    stable_since:      '0,
    last_release_time: '0,
    long_flag:         1'b0,
    double_flag:       1'b0,
    press_reported:    1'b0,
    release_reported:  1'b0
  };

  typedef struct packed {
    logic changed;
    logic pressed;
    logic long_pressed;
    logic just_pressed;
    logic just_released;
    logic double_clicked;
  } result_t;

endpackage

### src/button_debounce_long_double_click_core.sv
// Button debouncer with long-press and double-click detection, top level.
// Instantiates bdl_cfg and bdl_step; depends on bdl_pkg.
//
// Usage:
//   Input channel: one transaction per switch sample, carrying the raw pin
//   level and a free-running millisecond timestamp (wraps modulo 2^32).
//   Output channel: one transaction per sample with changed, pressed,
//   long_pressed and the one-shot just_pressed, just_released and
//   double_clicked events.
//   A sample is taken into an input register, evaluated against the stored
//   debouncer state by a single pass of short logic (two 32-bit subtracts and
//   three compares), and its result lands in an output register. Throughput
//   is one transaction per cycle while the output is not stalled.
//   When the receiver stalls, hold the result; the input register still takes
//   a new sample while the result register is free or being drained, and the
//   input stall rises only when both are full and the output is stalled.
//   Reset: the configuration returns to debounce 5 ms, long press 500 ms,
//   double click 200 ms, active low; the stored levels read released, all
//   flags clear, so the first result reports just_released.
//   Write configuration only while no transaction is in flight.
module button_debounce_long_double_click_core
  import bdl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write port
  input  logic             cfg_we_i,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  // sample channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             raw_level_i,
  input  logic [TimeW-1:0] time_ms_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             changed_o,
  output logic             pressed_o,
  output logic             long_pressed_o,
  output logic             just_pressed_o,
  output logic             just_released_o,
  output logic             double_clicked_o
);

  cfg_t             cfg;
  state_t           state_q, state_d;
  result_t          res_d, res_q;
  logic             in_vld_q;
  logic             raw_q;
  logic [TimeW-1:0] time_q;
  logic             out_vld_q;
  logic             out_free;
  logic             fire;
  logic             in_take;

  bdl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bdl_step u_step (
    .cfg_i       (cfg),
    .state_i     (state_q),
    .raw_level_i (raw_q),
    .time_ms_i   (time_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  // Result register can load when empty or being drained this cycle
  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= STATE_RST;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (out_free) begin
        out_vld_q <= fire;
      end
      // advance the debouncer state only when the sample is evaluated
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      raw_q  <= raw_level_i;
      time_q <= time_ms_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign changed_o        = res_q.changed;
  assign pressed_o        = res_q.pressed;
  assign long_pressed_o   = res_q.long_pressed;
  assign just_pressed_o   = res_q.just_pressed;
  assign just_released_o  = res_q.just_released;
  assign double_clicked_o = res_q.double_clicked;

endmodule

### src/bdl_cfg.sv
// Configuration register file for the button debouncer.
// Depends on bdl_pkg for the register indexes, reset values and cfg_t.
module bdl_cfg
  import bdl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= DEBOUNCE_RST;
      cfg_q.long_press_ms   <= LONG_PRESS_RST;
      cfg_q.double_click_ms <= DOUBLE_CLICK_RST;
      cfg_q.active_level    <= ACTIVE_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEBOUNCE:     cfg_q.debounce_ms     <= cfg_data_i;
        CFG_LONG_PRESS:   cfg_q.long_press_ms   <= cfg_data_i;
        CFG_DOUBLE_CLICK: cfg_q.double_click_ms <= cfg_data_i;
        CFG_ACTIVE_LEVEL: cfg_q.active_level    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/bdl_step.sv
// Combinational update for one sample: next debouncer state and the result.
// Depends on bdl_pkg for cfg_t, state_t and result_t.
module bdl_step
  import bdl_pkg::*;
(
  input  cfg_t             cfg_i,
  input  state_t           state_i,
  input  logic             raw_level_i,
  input  logic [TimeW-1:0] time_ms_i,
  output state_t           state_o,
  output result_t          result_o
);

  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] since_release;
  logic             deb_over;
  logic             long_over;
  logic             dbl_in;
  logic             pressed;
  logic             jp;
  logic             jr;
  logic             changed;
  state_t           nxt;

  assign elapsed       = time_ms_i - state_i.stable_since;
  assign since_release = time_ms_i - state_i.last_release_time;
  assign deb_over      = elapsed > {{(TimeW-CfgW){1'b0}}, cfg_i.debounce_ms};
  assign long_over     = elapsed > {{(TimeW-CfgW){1'b0}}, cfg_i.long_press_ms};
  assign dbl_in        = since_release < {{(TimeW-CfgW){1'b0}}, cfg_i.double_click_ms};

  always_comb begin
    nxt          = state_i;
    nxt.last_raw = raw_level_i;
    changed      = 1'b0;
    if (state_i.last_raw != raw_level_i) begin
      // restart the stable timer on any raw edge
      nxt.stable_since = time_ms_i;
    end else if (state_i.stable_level != raw_level_i && deb_over) begin
      nxt.stable_level     = raw_level_i;
      nxt.long_flag        = 1'b0;
      nxt.press_reported   = 1'b0;
      nxt.release_reported = 1'b0;
      if (raw_level_i != cfg_i.active_level) begin
        nxt.double_flag       = dbl_in;
        nxt.last_release_time = time_ms_i;
      end
      changed = 1'b1;
    end else if (!state_i.long_flag && long_over) begin
      nxt.long_flag = 1'b1;
      changed       = 1'b1;
    end

    pressed = (nxt.stable_level == cfg_i.active_level);
    jp      = pressed && !nxt.press_reported;
    jr      = !pressed && !nxt.release_reported;

    result_o.changed        = changed;
    result_o.pressed        = pressed;
    result_o.long_pressed   = pressed && nxt.long_flag;
    result_o.just_pressed   = jp;
    result_o.just_released  = jr;
    result_o.double_clicked = nxt.double_flag && jr;

    // consume the one-shot queries
    if (jp) nxt.press_reported = 1'b1;
    if (jr) nxt.release_reported = 1'b1;
    if (nxt.double_flag && jr) nxt.double_flag = 1'b0;

    state_o = nxt;
  end

endmodule

### tb/sv/bdl_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the button debouncer testbench: debouncer state, register copies
// and the queue of results still to arrive. Depends on bdl_pkg.
package bdl_check_pkg;
  import bdl_pkg::*;

  class debounce_scoreboard;
    cfg_t        cfg;
    state_t      btn;
    result_t     pending_results[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      cfg.debounce_ms     = DEBOUNCE_RST;
      cfg.long_press_ms   = LONG_PRESS_RST;
      cfg.double_click_ms = DOUBLE_CLICK_RST;
      cfg.active_level    = ACTIVE_LEVEL_RST;
      btn = STATE_RST;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        CFG_DEBOUNCE:     cfg.debounce_ms = val;
        CFG_LONG_PRESS:   cfg.long_press_ms = val;
        CFG_DOUBLE_CLICK: cfg.double_click_ms = val;
        CFG_ACTIVE_LEVEL: cfg.active_level = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Advance the debouncer by one sample and queue the result it must give.
    function void note_sample(logic raw, logic [TimeW-1:0] now);
      logic             prev, changed, pressed, jp, jr, dc;
      logic [TimeW-1:0] held, since_release;
      result_t          r;
      prev          = btn.last_raw;
      held          = now - btn.stable_since;
      since_release = now - btn.last_release_time;
      changed       = 1'b0;
      btn.last_raw  = raw;
      if (prev != raw) begin
        btn.stable_since = now;
      end else if (btn.stable_level != raw && held > TimeW'(cfg.debounce_ms)) begin
        btn.stable_level     = raw;
        btn.long_flag        = 1'b0;
        btn.press_reported   = 1'b0;
        btn.release_reported = 1'b0;
        if (raw != cfg.active_level) begin
          btn.double_flag       = (since_release < TimeW'(cfg.double_click_ms));
          btn.last_release_time = now;
        end
        changed = 1'b1;
      end else if (!btn.long_flag && held > TimeW'(cfg.long_press_ms)) begin
        btn.long_flag = 1'b1;
        changed       = 1'b1;
      end
      pressed = (btn.stable_level == cfg.active_level);
      jp = pressed && !btn.press_reported;
      jr = !pressed && !btn.release_reported;
      dc = btn.double_flag && jr;
      if (jp) btn.press_reported = 1'b1;
      if (jr) btn.release_reported = 1'b1;
      if (dc) btn.double_flag = 1'b0;
      r = '{changed, pressed, pressed && btn.long_flag, jp, jr, dc};
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 30) $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      string   names[6];
      names = '{"changed", "pressed", "long_pressed", "just_pressed", "just_released",
                "double_clicked"};
      checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding", checked));
        return;
      end
      want = pending_results.pop_front();
      for (int i = 0; i < 6; i++) begin
        if (got[5-i] !== want[5-i])
          report_mismatch($sformatf("result %0d: %s is %b, should be %b",
                                    checked, names[i], got[5-i], want[5-i]));
      end
    endtask
  endclass

endpackage

### tb/sv/button_debounce_long_double_click_core_tb.sv
`timescale 1ns / 1ps
// Top-level testbench for button_debounce_long_double_click_core: drives samples and
// register writes, stalls the result side. Depends on bdl_pkg and bdl_check_pkg.
module button_debounce_long_double_click_core_tb;
  import bdl_pkg::*;
  import bdl_check_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldOff    = 60;

  typedef struct {
    logic             raw;
    logic [TimeW-1:0] stamp;
  } sample_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]  cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             raw_level_i;
  logic [TimeW-1:0] time_ms_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             changed_o;
  logic             pressed_o;
  logic             long_pressed_o;
  logic             just_pressed_o;
  logic             just_released_o;
  logic             double_clicked_o;

  debounce_scoreboard sb;
  sample_t            stim_q[$];
  logic [TimeW-1:0]   cur_time;
  bit                 hold_req;
  int unsigned        cycle_count;

  button_debounce_long_double_click_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .raw_level_i      (raw_level_i),
    .time_ms_i        (time_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .changed_o        (changed_o),
    .pressed_o        (pressed_o),
    .long_pressed_o   (long_pressed_o),
    .just_pressed_o   (just_pressed_o),
    .just_released_o  (just_released_o),
    .double_clicked_o (double_clicked_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Guard against a hung handshake: give up well beyond the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result monitor. Outputs are read in the active region of the edge, so they still
  // hold the values the block presented before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({changed_o, pressed_o, long_pressed_o, just_pressed_o,
                       just_released_o, double_clicked_o});
  end

  // Result sink: stall on one of four patterns, redrawn at random when its run ends.
  // A hold-off request from the main sequence makes it refuse every transaction
  // until its hold-off count runs out, so the block fills and must stall its input.
  initial begin : result_sink
    int unsigned mode, mode_left, hold_left;
    mode        = 0;
    mode_left   = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HoldOff;
        hold_req  = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(3, 0);
        mode_left = $urandom_range(80, 10);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(3, 0) == 0);
          2:       out_stall_i <= ($urandom_range(9, 0) < 7);
          default: out_stall_i <= mode_left[1];
        endcase
      end
    end
  end

  // Queue a sample at an absolute timestamp.
  function automatic void add_sample(logic raw, logic [TimeW-1:0] stamp);
    sample_t s;
    s.raw    = raw;
    s.stamp  = stamp;
    cur_time = stamp;
    stim_q.push_back(s);
  endfunction

  // Queue a sample dt ms after the previous one; the timestamp wraps.
  function automatic void push_sample(logic raw, int unsigned dt);
    add_sample(raw, cur_time + dt);
  endfunction

  // Hold one level for at least target ms, spread over a few samples.
  function automatic int unsigned hold_level(logic level, int unsigned target);
    int unsigned n, step;
    n    = $urandom_range(5, 1);
    step = target / n + 1;
    repeat (n) push_sample(level, step + $urandom_range(step / 4, 0));
    return n;
  endfunction

  // One well-formed press and release: bounce, hold, bounce, hold. Hold lengths are
  // drawn around the current delays so that debounce, long press and double click
  // all get reached, with bounce timing left random.
  function automatic int unsigned gen_click();
    int unsigned deb, lp, dcw, target, cnt;
    logic        act;
    deb = 32'(sb.cfg.debounce_ms);
    lp  = 32'(sb.cfg.long_press_ms);
    dcw = 32'(sb.cfg.double_click_ms);
    act = sb.cfg.active_level;
    cnt = 0;
    repeat ($urandom_range(3, 0)) begin
      push_sample(act, $urandom_range(deb, 0));
      push_sample(!act, $urandom_range(deb, 0));
      cnt += 2;
    end
    push_sample(act, $urandom_range(deb, 0));
    target = ($urandom_range(3, 0) == 0) ? lp + 1 + $urandom_range(lp / 4 + 2, 0)
                                         : deb + 1 + $urandom_range(deb + 4, 0);
    cnt += 1 + hold_level(act, target);
    repeat ($urandom_range(3, 0)) begin
      push_sample(!act, $urandom_range(deb, 0));
      push_sample(act, $urandom_range(deb, 0));
      cnt += 2;
    end
    push_sample(!act, $urandom_range(deb, 0));
    target = ($urandom_range(2, 0) == 0) ? deb + 1 + $urandom_range(dcw, 0)
                                         : deb + 1 + $urandom_range(lp + dcw + 4, 0);
    cnt += 1 + hold_level(!act, target);
    return cnt;
  endfunction

  // A few samples of random level: repeated stamps, short steps and wild jumps.
  function automatic int unsigned gen_noise();
    int unsigned n, deb;
    n   = $urandom_range(4, 1);
    deb = 32'(sb.cfg.debounce_ms);
    repeat (n) begin
      case ($urandom_range(3, 0))
        0:       push_sample(1'($urandom_range(1, 0)), 0);
        1:       add_sample(1'($urandom_range(1, 0)), $urandom);
        default: push_sample(1'($urandom_range(1, 0)), $urandom_range(2 * deb + 2, 0));
      endcase
    end
    return n;
  endfunction

  task automatic write_cfg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // Write all four registers; the unused upper bits of the level write carry junk.
  task automatic set_config(input logic [CfgW-1:0] deb, lp, dcw, input logic act);
    logic [CfgW-1:0] junk;
    junk = CfgW'($urandom);
    write_cfg(CFG_DEBOUNCE, deb);
    write_cfg(CFG_LONG_PRESS, lp);
    write_cfg(CFG_DOUBLE_CLICK, dcw);
    write_cfg(CFG_ACTIVE_LEVEL, {junk[CfgW-1:1], act});
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every outstanding result has been taken, then let the pipeline settle.
  // Always wait on the clock before checking, so valid is never lowered and raised in one step.
  task automatic wait_idle();
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Offer the queued samples in bursts with random gaps. Hold each payload until it
  // is taken; after transaction pause_at, drop valid until the result side is empty.
  task automatic drive_stim(input int pause_at);
    sample_t     s;
    int unsigned burst, gap;
    int          sent;
    burst = 0;
    sent  = 0;
    while (stim_q.size() != 0) begin
      if (burst == 0) begin
        burst = $urandom_range(16, 1);
        gap   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      s = stim_q.pop_front();
      in_valid_i  <= 1'b1;
      raw_level_i <= s.raw;
      time_ms_i   <= s.stamp;
      do @(posedge clk_i); while (in_stall_o);
      sb.note_sample(s.raw, s.stamp);
      sent++;
      burst--;
      if (sent == pause_at) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
        burst = 0;
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin : main_seq
    int unsigned n;
    sb          = new();
    hold_req    = 1'b0;
    cycle_count = 0;
    cur_time    = '0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_DEBOUNCE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    raw_level_i = 1'b1;
    time_ms_i   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings (5 / 500 / 200 ms, active low).
    add_sample(1'b1, 32'd0);            // first sample after reset reports a release
    add_sample(1'b0, 32'd10);           // raw edge: timer restarts, nothing changes
    add_sample(1'b0, 32'd16);           // stable past debounce: pressed
    add_sample(1'b0, 32'd600);          // held past long press
    add_sample(1'b1, 32'd601);
    add_sample(1'b1, 32'd607);          // release, too late for a double click
    add_sample(1'b0, 32'd620);
    add_sample(1'b0, 32'd630);
    add_sample(1'b1, 32'd640);
    add_sample(1'b1, 32'd650);          // second release inside the window
    add_sample(1'b1, 32'd2000);         // long flag while released
    add_sample(1'b0, 32'hFFFF_FFFE);
    add_sample(1'b0, 32'h0000_0005);    // stable time measured across the wrap
    add_sample(1'b0, 32'hFFFF_FFFF);
    drive_stim(-1);
    wait_idle();

    // Flip the meaning of the level: the stored level now reads as released.
    write_cfg(CFG_ACTIVE_LEVEL, 16'h0001);
    cfg_we_i <= 1'b0;
    add_sample(1'b0, 32'h0000_0010);
    add_sample(1'b1, 32'h0000_0020);
    add_sample(1'b1, 32'h0000_0030);
    add_sample(1'b1, 32'h0000_0400);
    drive_stim(-1);

    // Random phases, each under its own settings, the extremes first and a mixed one in phase 5.
    for (int phase = 0; phase < 9; phase++) begin
      wait_idle();
      case (phase)
        0:       set_config(16'd0, 16'd0, 16'd0, 1'b0);
        1:       set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        5:       set_config(16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
        default: set_config(CfgW'($urandom_range(40, 0)), CfgW'($urandom_range(400, 0)),
                            CfgW'($urandom_range(600, 0)), 1'($urandom_range(1, 0)));
      endcase
      cur_time = $urandom;
      if (phase == 2 || phase == 6) hold_req = 1'b1;
      n = 0;
      while (n < 42) begin
        if ($urandom_range(9, 0) < 7) n += gen_click();
        else n += gen_noise();
      end
      drive_stim((phase == 4) ? 25 : -1);
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
